// ===== rtl/core/nsf_pkg.sv =====
// nsf_pkg: shared types, constants and helpers for the sentence framer
`timescale 1ns / 1ps
`default_nettype none

package nsf_pkg;

  // longest sentence kept, '$' included, CR LF excluded
  localparam int unsigned MAX_SENTENCE = 128;
  localparam int unsigned COUNT_W      = 8;

  // decoupling queue between front and back (power of two)
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = QPTR_W + 1;

  // character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // prefix position of the delimiter after the five prefix characters
  localparam logic [COUNT_W-1:0] DELIM_POS = COUNT_W'(6);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_TAIL = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_BAD_PFX  = 3'd3,
    ST_NO_DATA  = 3'd4,
    ST_TOO_LONG = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_GGA   = 2'd0,
    KIND_VTG   = 2'd1,
    KIND_GST   = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  // input word
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       discard;
  } in_word_t;

  // result word
  typedef struct packed {
    status_t     status;
    kind_t       sentence_kind;
    logic [39:0] prefix_chars;
    logic [6:0]  data_bytes;
    logic [7:0]  received_checksum;
    logic [7:0]  computed_checksum;
  } out_word_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       discard;
    logic       is_dollar;
    logic       is_cr;
    logic       is_lf;
    logic       is_delim;
  } cls_word_t;

  function automatic logic is_delim(logic [7:0] b);
    return (b == CH_COMMA) || (b == CH_STAR);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nsf_front.sv =====
// nsf_front: classifies each incoming word for the framer back end
`timescale 1ns / 1ps
`default_nettype none

module nsf_front import nsf_pkg::*; (
  input  wire in_word_t  item,
  output cls_word_t      cls
);

  // byte classification
  always_comb begin
    cls.data      = item.rx_byte;
    cls.discard   = item.discard;
    cls.is_dollar = (item.rx_byte == CH_DOLLAR);
    cls.is_cr     = (item.rx_byte == CH_CR);
    cls.is_lf     = (item.rx_byte == CH_LF);
    cls.is_delim  = is_delim(item.rx_byte);
  end

endmodule

`default_nettype wire

// ===== rtl/core/nsf_queue.sv =====
// nsf_queue: short register queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none

module nsf_queue import nsf_pkg::*; (
  input  wire             clk,
  input  wire             rst,
  input  wire             wr_en,
  input  wire cls_word_t  wr_data,
  output logic            full,
  output logic            valid,
  input  wire             rd_en,
  output cls_word_t       rd_data
);

  cls_word_t          slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign valid   = (count != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (do_rd && !do_wr) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on read");

endmodule

`default_nettype wire

// ===== rtl/core/nsf_back.sv =====
// nsf_back: sentence framing, checksum check and result register
`timescale 1ns / 1ps
`default_nettype none

module nsf_back import nsf_pkg::*; (
  input  wire             clk,
  input  wire             rst,
  input  wire             cfg_we,
  input  wire             cfg_data,
  input  wire             q_valid,
  input  wire cls_word_t  q_data,
  output logic            q_rd,
  output out_word_t       result,
  output logic            empty,
  input  wire             pop
);

  // running sentence state
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [7:0]         xsum;
    logic [7:0]         r0;
    logic [7:0]         r1;
    logic [7:0]         r2;
    logic [39:0]        prefix;
    logic               prefix_ok;
    logic               too_long;
  } sent_t;

  logic       report_failures;
  logic       in_sentence;
  logic       in_sentence_next;
  logic       pending_cr;
  logic       pending_cr_next;
  sent_t      st;
  sent_t      st_next;
  sent_t      work;
  logic       res_valid;
  logic       go;
  logic       finish;
  logic       emit;
  out_word_t  fin_word;

  // tail check values
  logic       tail_ok;
  logic       pfx_ok;
  logic       hi_ok;
  logic       lo_ok;
  logic [3:0] hi_val;
  logic [3:0] lo_val;
  logic [7:0] rx_sum;
  logic [7:0] cx_sum;
  logic [7:0] dlen_raw;
  logic [6:0] dlen;
  kind_t      kind;

  function automatic sent_t keep_byte(sent_t s, logic [7:0] b, logic delim);
    sent_t r;
    r = s;
    if (s.count >= COUNT_W'(MAX_SENTENCE)) begin
      r.too_long = 1'b1;
    end else begin
      if (s.count >= COUNT_W'(1) && s.count <= COUNT_W'(5)) begin
        r.prefix = {s.prefix[31:0], b};
        if (delim) begin
          r.prefix_ok = 1'b0;
        end
      end else if (s.count == DELIM_POS) begin
        if (!delim) begin
          r.prefix_ok = 1'b0;
        end
      end
      r.xsum  = s.xsum ^ b;
      r.r2    = s.r1;
      r.r1    = s.r0;
      r.r0    = b;
      r.count = s.count + 1'b1;
    end
    return r;
  endfunction

  // hex digit value, {valid, value}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] v;
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  function automatic kind_t classify(logic [39:0] p);
    kind_t k;
    k = KIND_OTHER;
    if (p[39:32] == "G" &&
        (p[31:24] == "P" || p[31:24] == "L" || p[31:24] == "A" || p[31:24] == "N")) begin
      if (p[23:0] == "GGA") begin
        k = KIND_GGA;
      end else if (p[23:0] == "VTG") begin
        k = KIND_VTG;
      end else if (p[23:0] == "GST") begin
        k = KIND_GST;
      end
    end
    return k;
  endfunction

  // a word moves on while the result register is free or drains this cycle
  assign go    = q_valid && (!res_valid || pop);
  assign q_rd  = go;
  assign empty = !res_valid;

  // end of sentence evaluation
  always_comb begin
    tail_ok  = (st.count >= COUNT_W'(4)) && (st.r2 == CH_STAR) &&
               (st.r1 != CH_STAR) && (st.r0 != CH_STAR);
    pfx_ok   = st.prefix_ok && (st.count >= COUNT_W'(7));
    {hi_ok, hi_val} = hex_digit(st.r1);
    {lo_ok, lo_val} = hex_digit(st.r0);
    rx_sum   = {hi_val, lo_val};
    cx_sum   = st.xsum ^ st.r2 ^ st.r1 ^ st.r0;
    dlen_raw = st.count - COUNT_W'(10);
    if (st.count > COUNT_W'(10)) begin
      dlen = (dlen_raw > 8'd127) ? 7'd127 : dlen_raw[6:0];
    end else begin
      dlen = '0;
    end
    kind = pfx_ok ? classify(st.prefix) : KIND_OTHER;

    fin_word.sentence_kind     = kind;
    fin_word.prefix_chars      = st.prefix;
    fin_word.data_bytes        = '0;
    fin_word.received_checksum = '0;
    fin_word.computed_checksum = '0;
    if (st.too_long) begin
      fin_word.status = ST_TOO_LONG;
    end else if (!tail_ok) begin
      fin_word.status = ST_BAD_TAIL;
    end else begin
      fin_word.data_bytes        = dlen;
      fin_word.received_checksum = rx_sum;
      fin_word.computed_checksum = cx_sum;
      if (!hi_ok || !lo_ok || rx_sum != cx_sum) begin
        fin_word.status = ST_MISMATCH;
      end else if (!pfx_ok) begin
        fin_word.status = ST_BAD_PFX;
      end else if (st.count <= COUNT_W'(10)) begin
        fin_word.status = ST_NO_DATA;
      end else begin
        fin_word.status = ST_OK;
      end
    end
  end

  // framing step for one word
  always_comb begin
    st_next          = st;
    in_sentence_next = in_sentence;
    pending_cr_next  = pending_cr;
    finish           = 1'b0;
    work             = st;
    if (go) begin
      if (q_data.discard) begin
        in_sentence_next = 1'b0;
        pending_cr_next  = 1'b0;
      end else if (!in_sentence) begin
        if (q_data.is_dollar) begin
          in_sentence_next  = 1'b1;
          pending_cr_next   = 1'b0;
          st_next           = '0;
          st_next.count     = COUNT_W'(1);
          st_next.prefix_ok = 1'b1;
        end
      end else begin
        // a held CR is either the end marker or ordinary payload
        if (pending_cr) begin
          if (q_data.is_lf) begin
            finish = 1'b1;
          end else begin
            work            = keep_byte(work, CH_CR, 1'b0);
            pending_cr_next = 1'b0;
          end
        end
        if (finish) begin
          in_sentence_next = 1'b0;
          pending_cr_next  = 1'b0;
        end else begin
          if (q_data.is_cr) begin
            pending_cr_next = 1'b1;
          end else begin
            work = keep_byte(work, q_data.data, q_data.is_delim);
          end
          st_next = work;
        end
      end
    end
    emit = finish && ((fin_word.status == ST_OK) || report_failures);
  end

  // config register and framer state
  always_ff @(posedge clk) begin
    if (rst) begin
      report_failures <= 1'b0;
      in_sentence     <= 1'b0;
      pending_cr      <= 1'b0;
      st              <= '0;
    end else begin
      if (cfg_we) begin
        report_failures <= cfg_data;
      end
      in_sentence <= in_sentence_next;
      pending_cr  <= pending_cr_next;
      st          <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go) begin
      res_valid <= emit;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      result <= fin_word;
    end
  end

  a_cr_in_sentence: assert property (@(posedge clk) disable iff (rst)
    pending_cr |-> in_sentence)
    else $error("pending CR outside a sentence");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    in_sentence |-> (st.count >= COUNT_W'(1) && st.count <= COUNT_W'(MAX_SENTENCE)))
    else $error("sentence byte count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !pop) |=> (res_valid && $stable(result)))
    else $error("result register overwritten before pop");

endmodule

`default_nettype wire

// ===== rtl/core/nmea_sentence_framer_core.sv =====
// nmea_sentence_framer_core: top level of the NMEA sentence framer
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial NMEA 0183 sentence framer. Push one word per clock (a received
// byte, or a discard that drops any partial sentence); the block hunts for '$',
// gathers bytes up to CR LF, checks the '*hh' tail against the XOR of the body,
// checks and classes the five-character prefix and pops out one status word per
// sentence (failures only when report_failures is set). Sustained rate is one
// word per clock while results are popped: a classifier feeds a four-word queue,
// and the framer back end retires one queued word per cycle whenever its result
// register is empty or is being popped. A sentence's LF passes through the queue
// and its status word is then registered in the result register; full rises only
// when the back end is held by an unpopped result.
module nmea_sentence_framer_core import nsf_pkg::*; (
  input  wire             clk,
  input  wire             rst,
  input  wire in_word_t   item,
  input  wire             push,
  output logic            full,
  output out_word_t       result,
  output logic            empty,
  input  wire             pop,
  input  wire             cfg_we,
  input  wire             cfg_data
);

  cls_word_t  cls;
  cls_word_t  q_data;
  logic       q_valid;
  logic       q_rd;

  // classifier
  nsf_front u_front (
    .item (item),
    .cls  (cls)
  );

  // decoupling queue
  nsf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cls),
    .full    (full),
    .valid   (q_valid),
    .rd_en   (q_rd),
    .rd_data (q_data)
  );

  // framer back end
  nsf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_rd     (q_rd),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

`default_nettype wire
